### hw/rtl/hffr_pkg.sv
package hffr_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int WIDX_W      = $clog2(FRAME_DEPTH + 1);
  localparam int COUNT_W     = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_PAYLOAD  = 3'd0;
  localparam kind_t KIND_EMPTY    = 3'd1;
  localparam kind_t KIND_LEN_ERR  = 3'd2;
  localparam kind_t KIND_TIMEOUT  = 3'd3;
  localparam kind_t KIND_OVERFLOW = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 2'd3;

  localparam logic [7:0]  BASE_RESET  = 8'd8;
  localparam logic [15:0] SLOPE_RESET = 16'd4588;

  // controller to datapath
  typedef struct packed {
    logic capture;      // latch the accepted input transaction
    logic step;         // apply the byte or tick to the frame state
    logic check;        // settle the timeout limit and test it
    logic out_single;   // load a one-shot result into the output register
    logic out_payload;  // load the fetched payload byte into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_single;  // this step ends in one result
    logic step_payload; // this step ends in a payload run
    logic timeout;      // check found the limit exceeded
    logic out_free;     // output register can take a result this cycle
    logic emit_last;    // fetched byte is the last of the payload
  } dp_sts_t;

endpackage

### hw/rtl/header_footer_frame_receiver.sv
// Header/footer frame receiver.
// Input channel (in_valid / in_stall, payload mode + rx_byte) carries one
// transaction per received byte (mode 0) or per millisecond tick (mode 1).
// Output channel (out_valid / out_stall, payload kind, data, payload_count,
// last) carries results: payload bytes of a good frame, a good-empty mark,
// or a length error, timeout or overflow report; last marks the final
// result caused by one input transaction.
// The block works on one input transaction at a time. A transaction that
// gives no result goes through accept, step and timeout check. A single
// result is loaded into the output register from the result state, after
// the step or the timeout check, once the output register is free.
// A good frame walks the frame store through its registered read port,
// with a fetch state and an emit state for each payload byte.
// When out_stall holds the output register, the block finishes the current
// step and waits with in_stall high; no result is dropped or repeated.
// A new input can be accepted while the last result still waits.
// Synchronous reset (rst) returns to hunting for the header, clears the
// timer and output valid, and restores default registers (base 8 ms,
// slope 0.07 ms per length unit in Q16). No clearing pass is needed.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module header_footer_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hffr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hffr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hffr_pkg::kind_t                  kind,
  output logic [7:0]                       data,
  output logic [hffr_pkg::COUNT_W-1:0]     payload_count,
  output logic                             last
);

  hffr_pkg::ctl_cmd_t cmd;
  hffr_pkg::dp_sts_t  sts;

  // sequencing: accept, step, check, result or payload walk
  hffr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // sync matching, frame store, timeout arithmetic and output register
  hffr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .rx_byte       (rx_byte),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .kind          (kind),
    .data          (data),
    .payload_count (payload_count),
    .last          (last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

### hw/rtl/hffr_ctrl.sv
module hffr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hffr_pkg::dp_sts_t  sts,
  output hffr_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_RESULT = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (sts.step_single) begin
          state_next = S_RESULT;
        end else if (sts.step_payload) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.timeout ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_single = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_payload = 1'b1;
          state_next      = sts.emit_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/hffr_datapath.sv
module hffr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hffr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hffr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                mode,
  input  logic [7:0]                          rx_byte,
  input  logic                                out_stall,
  output logic                                out_valid,
  output hffr_pkg::kind_t                     kind,
  output logic [7:0]                          data,
  output logic [hffr_pkg::COUNT_W-1:0]        payload_count,
  output logic                                last,
  input  hffr_pkg::ctl_cmd_t                  cmd,
  output hffr_pkg::dp_sts_t                   sts
);

  // configuration
  logic [15:0] header_word;
  logic [15:0] footer_word;
  logic [7:0]  timeout_base;
  logic [15:0] timeout_slope;

  // captured transaction
  logic       it_mode;
  logic [7:0] it_byte;

  // frame state
  logic                           in_frame;
  logic                           match_index;
  logic [hffr_pkg::WIDX_W-1:0]    write_index;
  logic                           length_seen;
  logic                           timer_armed;
  logic [15:0]                    timeout_limit;
  logic [15:0]                    elapsed_ms;
  logic                           arm_pending;
  logic [23:0]                    product;
  logic [7:0]                     first_byte;
  hffr_pkg::kind_t                pend_kind;
  logic [hffr_pkg::COUNT_W-1:0]   pay_count;
  logic [hffr_pkg::ADDR_W-1:0]    rd_addr;
  logic [7:0]                     rd_data;

  logic [7:0] frame_store [hffr_pkg::FRAME_DEPTH];

  logic [7:0]                     hdr_sel;
  logic [7:0]                     ftr_sel;
  logic [hffr_pkg::WIDX_W-1:0]    count_raw;
  logic                           overflow;
  logic                           store_byte;
  logic                           footer_done;
  logic                           length_good;
  logic [8:0]                     limit_sum;
  logic [15:0]                    limit_eff;
  logic                           timed_out;

  assign hdr_sel   = match_index ? header_word[7:0] : header_word[15:8];
  assign ftr_sel   = match_index ? footer_word[7:0] : footer_word[15:8];
  assign count_raw = write_index - hffr_pkg::WIDX_W'(2);

  assign overflow    = !it_mode && in_frame &&
                       (write_index >= hffr_pkg::WIDX_W'(hffr_pkg::FRAME_DEPTH));
  assign store_byte  = !it_mode && in_frame && !overflow;
  assign footer_done = store_byte && (it_byte == ftr_sel) && match_index;
  assign length_good = (write_index >= hffr_pkg::WIDX_W'(2)) &&
                       (first_byte == 8'(count_raw));

  assign limit_sum = {1'b0, timeout_base} + {1'b0, product[23:16]};
  assign limit_eff = arm_pending ? 16'(limit_sum) : timeout_limit;
  assign timed_out = timer_armed && (elapsed_ms > limit_eff);

  assign sts.step_single  = overflow ||
                            (footer_done && !(length_good && (count_raw != '0)));
  assign sts.step_payload = footer_done && length_good && (count_raw != '0);
  assign sts.timeout      = timed_out;
  assign sts.out_free     = !out_valid || !out_stall;
  assign sts.emit_last    = (hffr_pkg::COUNT_W'(rd_addr) == pay_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word   <= '0;
      footer_word   <= '0;
      timeout_base  <= hffr_pkg::BASE_RESET;
      timeout_slope <= hffr_pkg::SLOPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hffr_pkg::CFG_HEADER: header_word   <= cfg_data;
        hffr_pkg::CFG_FOOTER: footer_word   <= cfg_data;
        hffr_pkg::CFG_BASE:   timeout_base  <= cfg_data[7:0];
        hffr_pkg::CFG_SLOPE:  timeout_slope <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode <= mode;
      it_byte <= rx_byte;
    end
  end

  // frame store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.step && store_byte) begin
      frame_store[write_index[hffr_pkg::ADDR_W-1:0]] <= it_byte;
    end
    rd_data <= frame_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      product <= {16'd0, it_byte} * {8'd0, timeout_slope};
      if (store_byte && (write_index == '0)) begin
        first_byte <= it_byte;
      end
      if (footer_done) begin
        pay_count <= hffr_pkg::COUNT_W'(count_raw);
        rd_addr   <= hffr_pkg::ADDR_W'(1);
        if (length_good) begin
          pend_kind <= hffr_pkg::KIND_EMPTY;
        end else begin
          pend_kind <= hffr_pkg::KIND_LEN_ERR;
        end
      end else if (overflow) begin
        pend_kind <= hffr_pkg::KIND_OVERFLOW;
      end
    end else if (cmd.check) begin
      pend_kind <= hffr_pkg::KIND_TIMEOUT;
    end else if (cmd.out_payload) begin
      rd_addr <= rd_addr + hffr_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      match_index   <= 1'b0;
      write_index   <= '0;
      length_seen   <= 1'b0;
      timer_armed   <= 1'b0;
      timeout_limit <= '0;
      elapsed_ms    <= '0;
      arm_pending   <= 1'b0;
    end else if (cmd.step) begin
      arm_pending <= 1'b0;
      if (it_mode) begin
        if (elapsed_ms != 16'hFFFF) begin
          elapsed_ms <= elapsed_ms + 16'd1;
        end
      end else if (!in_frame) begin
        if (it_byte == hdr_sel) begin
          if (match_index) begin
            match_index <= 1'b0;
            in_frame    <= 1'b1;
            write_index <= '0;
            elapsed_ms  <= '0;
          end else begin
            match_index <= 1'b1;
          end
        end else begin
          match_index <= 1'b0;
        end
      end else if (overflow || footer_done) begin
        in_frame    <= 1'b0;
        match_index <= 1'b0;
        write_index <= '0;
        length_seen <= 1'b0;
        timer_armed <= 1'b0;
      end else begin
        if (!length_seen) begin
          arm_pending <= 1'b1;
          timer_armed <= 1'b1;
          length_seen <= 1'b1;
        end
        write_index <= write_index + hffr_pkg::WIDX_W'(1);
        if (it_byte == ftr_sel) begin
          match_index <= 1'b1;
        end else begin
          match_index <= match_index && (it_byte == footer_word[15:8]);
        end
      end
    end else if (cmd.check) begin
      arm_pending   <= 1'b0;
      timeout_limit <= limit_eff;
      if (timed_out) begin
        in_frame    <= 1'b0;
        match_index <= 1'b0;
        write_index <= '0;
        length_seen <= 1'b0;
        timer_armed <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_single || cmd.out_payload) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_single) begin
      kind          <= pend_kind;
      data          <= '0;
      payload_count <= '0;
      last          <= 1'b1;
    end else if (cmd.out_payload) begin
      kind          <= hffr_pkg::KIND_PAYLOAD;
      data          <= rd_data;
      payload_count <= pay_count;
      last          <= sts.emit_last;
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  // One expected output transaction of the deframer.
  typedef struct {
    hffr_pkg::kind_t                kind;
    logic [7:0]                     data;
    logic [hffr_pkg::COUNT_W-1:0]   count;
    logic                           last;
  } frame_result_t;

  // Scoreboard: mirrors the deframer state, turns every accepted input
  // transaction into the results it causes, and checks the output stream
  // against them in order.
  class deframe_scoreboard;
    logic [15:0]  hdr_word;
    logic [15:0]  ftr_word;
    logic [7:0]   tmo_base;
    logic [15:0]  tmo_slope;

    bit           framing;
    bit           sync_pos;
    int           fill;
    logic [7:0]   store [hffr_pkg::FRAME_DEPTH];
    bit           len_seen;
    bit           timer_on;
    logic [15:0]  limit_ms;
    logic [15:0]  ms_count;

    frame_result_t due_results [$];
    int           errors;

    function new();
      hdr_word  = '0;
      ftr_word  = '0;
      tmo_base  = hffr_pkg::BASE_RESET;
      tmo_slope = hffr_pkg::SLOPE_RESET;
      framing   = 1'b0;
      sync_pos  = 1'b0;
      fill      = 0;
      foreach (store[i]) store[i] = '0;
      len_seen  = 1'b0;
      timer_on  = 1'b0;
      limit_ms  = '0;
      ms_count  = '0;
      errors    = 0;
    endfunction

    function void configure(logic [hffr_pkg::CFG_IDX_W-1:0] idx,
                            logic [hffr_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        hffr_pkg::CFG_HEADER: hdr_word  = value;
        hffr_pkg::CFG_FOOTER: ftr_word  = value;
        hffr_pkg::CFG_BASE:   tmo_base  = value[7:0];
        hffr_pkg::CFG_SLOPE:  tmo_slope = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] sync_of(logic [15:0] word, bit pos);
      return pos ? word[7:0] : word[15:8];
    endfunction

    function void abort_frame();
      framing  = 1'b0;
      sync_pos = 1'b0;
      fill     = 0;
      len_seen = 1'b0;
      timer_on = 1'b0;
    endfunction

    function void push(hffr_pkg::kind_t k, logic [7:0] d, int cnt, bit lst);
      frame_result_t r;
      r.kind  = k;
      r.data  = d;
      r.count = hffr_pkg::COUNT_W'(cnt);
      r.last  = lst;
      due_results.push_back(r);
    endfunction

    // Advance the mirrored state by one byte or tick and queue its results.
    function void note_rx(bit tick, logic [7:0] b);
      int          produced;
      int          cnt;
      logic [31:0] prod;
      produced = 0;
      if (tick) begin
        if (ms_count != 16'hFFFF) ms_count++;
      end else if (!framing) begin
        if (b == sync_of(hdr_word, sync_pos)) begin
          if (sync_pos) begin
            sync_pos = 1'b0;
            framing  = 1'b1;
            fill     = 0;
            ms_count = '0;
          end else begin
            sync_pos = 1'b1;
          end
        end else begin
          sync_pos = 1'b0;
        end
      end else if (fill >= hffr_pkg::FRAME_DEPTH) begin
        abort_frame();
        push(hffr_pkg::KIND_OVERFLOW, 8'h00, 0, 1'b1);
        produced = 1;
      end else begin
        if (!len_seen) begin
          prod     = {24'd0, b} * {16'd0, tmo_slope};
          timer_on = 1'b1;
          len_seen = 1'b1;
          limit_ms = {8'd0, tmo_base} + prod[31:16];
        end
        store[fill] = b;
        fill++;
        if (b == sync_of(ftr_word, sync_pos)) begin
          if (sync_pos) begin
            cnt = fill - 3;
            abort_frame();
            if (cnt >= 0 && int'(store[0]) == cnt) begin
              if (cnt == 0) begin
                push(hffr_pkg::KIND_EMPTY, 8'h00, 0, 1'b1);
              end else begin
                for (int k = 0; k < cnt; k++)
                  push(hffr_pkg::KIND_PAYLOAD, store[k + 1], cnt, k == cnt - 1);
              end
            end else begin
              push(hffr_pkg::KIND_LEN_ERR, 8'h00, 0, 1'b1);
            end
            produced = 1;
          end else begin
            sync_pos = 1'b1;
          end
        end else begin
          sync_pos = sync_pos && (b == ftr_word[15:8]);
        end
      end
      if (produced == 0 && timer_on && ms_count > limit_ms) begin
        abort_frame();
        push(hffr_pkg::KIND_TIMEOUT, 8'h00, 0, 1'b1);
      end
    endfunction

    function void report(string field, int want, int got);
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(hffr_pkg::kind_t k, logic [7:0] d,
                               logic [hffr_pkg::COUNT_W-1:0] cnt, logic lst);
      frame_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, %s %0d data %0d count %0d last %0d",
                 $time, "actual kind", k, d, cnt, lst);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (k !== want.kind)    report("kind", want.kind, k);
      if (d !== want.data)    report("data", want.data, d);
      if (cnt !== want.count) report("payload_count", want.count, cnt);
      if (lst !== want.last)  report("last", want.last, lst);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [hffr_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [hffr_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic                             mode;
  logic [7:0]                       rx_byte;
  logic                             out_valid;
  logic                             out_stall;
  hffr_pkg::kind_t                  kind;
  logic [7:0]                       data;
  logic [hffr_pkg::COUNT_W-1:0]     payload_count;
  logic                             last;

  deframe_scoreboard sb;
  int  items_sent;
  bit  quiet;       // no idling on either side while set
  bit  hold_req;    // ask the receiver for one long hold-off
  int  hold_left;

  header_footer_frame_receiver u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .data          (data),
    .payload_count (payload_count),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: pick the stall level at the falling edge, then take the
  // transaction at the rising edge. A pending hold-off request turns into
  // a long run of stall counted here.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !quiet && ($urandom_range(99) < 16);
      end
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall)
        sb.check_result(kind, data, payload_count, last);
    end
  end

  // Offer one byte or tick, starting at a falling edge; return at the
  // falling edge after it was taken, with valid still high so a following
  // item goes out back to back.
  task automatic put_item(input bit tick, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = tick;
    rx_byte  = b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_rx(tick, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_header();
    put_item(1'b0, sb.hdr_word[15:8]);
    put_item(1'b0, sb.hdr_word[7:0]);
  endtask

  task automatic send_footer();
    put_item(1'b0, sb.ftr_word[15:8]);
    put_item(1'b0, sb.ftr_word[7:0]);
  endtask

  // Drop valid and wait until every expected result is out, then give the
  // block time to finish a step that produces nothing.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [hffr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hffr_pkg::CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    sb.configure(idx, value);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] hdr, ftr, input logic [7:0] base,
                            input logic [15:0] slope);
    write_reg(hffr_pkg::CFG_HEADER, hdr);
    write_reg(hffr_pkg::CFG_FOOTER, ftr);
    write_reg(hffr_pkg::CFG_BASE, {8'd0, base});
    write_reg(hffr_pkg::CFG_SLOPE, slope);
    cfg_we = 1'b0;
  endtask

  // One stimulus sequence, chosen by pick (0..99):
  //   noise, broken header, timeout, overflow, length error, good frame.
  task automatic send_frame(input int pick);
    int         len;
    int         lim;
    int         tick_pct;
    logic [7:0] b;
    if (pick < 10) begin
      // noise while hunting: random bytes and ticks
      len = $urandom_range(1, 6);
      repeat (len) put_item(1'($urandom_range(1)), 8'($urandom));
    end else if (pick < 16) begin
      // first header byte, then anything
      put_item(1'b0, sb.hdr_word[15:8]);
      put_item(1'b0, 8'($urandom));
    end else if (pick < 30) begin
      // run the timer out after or before the length byte; for a large limit, close the frame instead
      b   = 8'($urandom);
      lim = int'(sb.tmo_base) + int'((32'(b) * 32'(sb.tmo_slope)) >> 16);
      send_header();
      if (lim > 30) begin
        put_item(1'b0, b);
        repeat (2) put_item(1'b1, 8'($urandom));
        send_footer();
      end else if ($urandom_range(1)) begin
        put_item(1'b0, b);
        repeat (lim + 1) put_item(1'b1, 8'($urandom));
      end else begin
        repeat (lim + 1) put_item(1'b1, 8'($urandom));
        put_item(1'b0, b);
      end
    end else if (pick < 32) begin
      // overflow: keep clear of the footer so the store fills up
      send_header();
      repeat (hffr_pkg::FRAME_DEPTH + 1) begin
        b = 8'($urandom);
        if (b == sb.ftr_word[15:8]) b = b ^ 8'h01;
        put_item(1'b0, b);
      end
    end else begin
      lim = $urandom_range(99);
      if (lim < 80)      len = $urandom_range(0, 6);
      else if (lim < 95) len = $urandom_range(7, 20);
      else               len = hffr_pkg::FRAME_DEPTH - 3;
      tick_pct = (pick >= 92) ? 25 : 4;
      send_header();
      // a wrong length byte for the length error cases
      put_item(1'b0, (pick < 44) ? 8'($urandom) : 8'(len));
      repeat (len) begin
        if ($urandom_range(99) < tick_pct) put_item(1'b1, 8'($urandom));
        put_item(1'b0, 8'($urandom));
      end
      send_footer();
    end
  endtask

  initial begin
    sb         = new();
    items_sent = 0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = hffr_pkg::CFG_HEADER;
    cfg_data   = '0;
    in_valid   = 1'b0;
    mode       = 1'b0;
    rx_byte    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: all-zero sync words.
    while (items_sent < 30) send_frame($urandom_range(99));
    drain();

    set_config(16'hA55A, 16'h0D0A, 8'd8, 16'd4588);
    // A mismatch at the second header byte is not retried as a first byte.
    put_item(1'b0, 8'hA5);
    put_item(1'b0, 8'hA5);
    put_item(1'b0, 8'h5A);
    // Empty good frame.
    send_header();
    put_item(1'b0, 8'h00);
    send_footer();
    // Two payload bytes that break a partial footer match twice.
    send_header();
    put_item(1'b0, 8'h02);
    put_item(1'b0, 8'h0D);
    put_item(1'b0, 8'h0D);
    send_footer();
    // Footer right after the header: too short for a length.
    send_header();
    send_footer();
    // Largest length byte, no payload: length error.
    send_header();
    put_item(1'b0, 8'hFF);
    send_footer();
    put_item(1'b1, 8'hFF);
    send_frame(20);
    send_frame(50);

    // Long receiver hold-off while frames keep coming, then let it all drain.
    hold_req = 1'b1;
    repeat (4) send_frame(60);
    drain();
    while (items_sent < 90) send_frame($urandom_range(99));
    drain();

    // Zero timeout: any tick inside a frame aborts it. No idling here.
    set_config(16'hFFFF, 16'h0000, 8'd0, 16'd0);
    quiet = 1'b1;
    while (items_sent < 125) send_frame($urandom_range(99));
    drain();
    quiet = 1'b0;

    // Largest timeout settings, with one forced overflow.
    set_config(16'h0000, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_frame(30);
    while (items_sent < 170) send_frame($urandom_range(99));
    drain();

    set_config(16'h7E81, 16'h817E, 8'd3, 16'd20000);
    while (items_sent < 205) send_frame($urandom_range(99));
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
